// File: rtl/core/smvm_pkg.sv
// smvm_pkg: shared types and constants for the scaled matrix-vector multiply
// used by scaled_matrix_vector_multiply; no dependencies
package smvm_pkg;

  localparam int VAL_W  = 16;  // q8.8 entries, elements and scale
  localparam int IDX_W  = 4;   // row and column index fields
  localparam int CNT_W  = 5;   // row and column count registers
  localparam int ACC_W  = 36;  // exact sum of up to 16 q16.16 products
  localparam int PROD_W = ACC_W + VAL_W;
  localparam int RES_W  = 32;  // q24.8 result
  localparam int CIDX_W = 2;   // configuration register index

  localparam logic [CIDX_W-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_COLS  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SCALE = 2'd2;

  localparam logic FUNC_MATRIX = 1'b0;
  localparam logic FUNC_VECTOR = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] value;
    logic                    last_element;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic signed [RES_W-1:0] result_value;
    logic                    last_result;
  } out_item_t;

endpackage

// File: rtl/core/scaled_matrix_vector_multiply.sv
// scaled_matrix_vector_multiply: y = s*A*x in q8.8 with saturated q24.8 results
// depends on smvm_pkg for payload structs and constants
//
// Usage: an item is taken on a clock edge with start high and busy low. A matrix
// write or a vector element without the last flag leaves busy low. A vector
// element with the last flag starts the product over the clamped row and column
// counts, and busy stays high until the last result is shown. Each row
// streams its columns through one shared 36x16 multiplier, one multiply per
// cycle, then drains the three-stage read/multiply/accumulate pipe and reuses
// the same multiplier once for the scale. Results come out in row order, one
// cycle each on out_valid, and cannot be held off: the receiver must take every
// result in the cycle it is shown. The configuration channel is always ready;
// write it only while busy is low and no result is pending.
module scaled_matrix_vector_multiply
  import smvm_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]  cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VAW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RLIM  = (MAX_ROWS > 16) ? 16 : MAX_ROWS;
  localparam int CLIM  = (MAX_COLS > 16) ? 16 : MAX_COLS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_SCALE,
    S_EMIT
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        rows_cfg_r;
  logic [CNT_W-1:0]        cols_cfg_r;
  logic signed [VAL_W-1:0] scale_r;
  logic [CNT_W-1:0]        nr_r;
  logic [CNT_W-1:0]        nc_r;
  logic [IDX_W-1:0]        row_r;
  logic [IDX_W-1:0]        col_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  // memories
  logic [VAL_W-1:0] mat_mem [DEPTH];
  logic [VAL_W-1:0] vec_mem [MAX_COLS];
  logic signed [VAL_W-1:0] mat_q;
  logic signed [VAL_W-1:0] vec_q;

  // pipeline
  logic                     s1_vld_r, s1_first_r, s1_last_r;
  logic                     s2_vld_r, s2_first_r, s2_last_r;
  logic                     acc_done_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic                     accept;
  logic                     mat_wr, vec_wr;
  logic [MAW-1:0]           wr_addr, rd_addr;
  logic signed [ACC_W-1:0]  mul_a;
  logic signed [VAL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [RES_W-1:0]  sat_val;
  logic [CNT_W-1:0]         nr_nxt, nc_nxt;
  logic                     col_end;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept = start && !busy;
  assign mat_wr = accept && (in_data.func == FUNC_MATRIX) &&
                  (32'(in_data.row_index) < 32'(MAX_ROWS)) &&
                  (32'(in_data.col_index) < 32'(MAX_COLS));
  assign vec_wr = accept && (in_data.func == FUNC_VECTOR) &&
                  (32'(in_data.col_index) < 32'(MAX_COLS));
  assign wr_addr = MAW'(32'(in_data.row_index) * MAX_COLS + 32'(in_data.col_index));
  assign rd_addr = MAW'(32'(row_r) * MAX_COLS + 32'(col_r));

  always_ff @(posedge clk) begin
    if (mat_wr) begin
      mat_mem[wr_addr] <= in_data.value;
    end
    mat_q <= mat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vec_wr) begin
      vec_mem[VAW'(in_data.col_index)] <= in_data.value;
    end
    vec_q <= vec_mem[VAW'(col_r)];
  end

  // clamp counts to 1 .. limit
  always_comb begin
    nr_nxt = rows_cfg_r;
    if (nr_nxt == '0) nr_nxt = CNT_W'(1);
    if (nr_nxt > CNT_W'(RLIM)) nr_nxt = CNT_W'(RLIM);
    nc_nxt = cols_cfg_r;
    if (nc_nxt == '0) nc_nxt = CNT_W'(1);
    if (nc_nxt > CNT_W'(CLIM)) nc_nxt = CNT_W'(CLIM);
  end

  assign col_end = ({1'b0, col_r} == nc_r - CNT_W'(1));

  // shared multiplier: entry times element while streaming, sum times scale after
  always_comb begin
    if (state_r == S_SCALE) begin
      mul_a = acc_r;
      mul_b = scale_r;
    end else begin
      mul_a = {{(ACC_W-VAL_W){mat_q[VAL_W-1]}}, mat_q};
      mul_b = vec_q;
    end
  end
  assign mul_p = mul_a * mul_b;

  // floor shift to q24.8, then saturate
  assign shifted = prod_r[PROD_W-1:VAL_W];
  always_comb begin
    if (&shifted[ACC_W-1:RES_W-1] || ~|shifted[ACC_W-1:RES_W-1]) begin
      sat_val = shifted[RES_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_val = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(RES_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      s1_vld_r   <= (state_r == S_ISSUE);
      s2_vld_r   <= s1_vld_r;
      acc_done_r <= s2_vld_r && s2_last_r;
    end
    s1_first_r <= (col_r == '0);
    s1_last_r  <= col_end;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    prod_r     <= mul_p;
    if (s2_vld_r) begin
      if (s2_first_r) begin
        acc_r <= prod_r[ACC_W-1:0];
      end else begin
        acc_r <= acc_r + prod_r[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_cfg_r  <= CNT_W'(16);
      cols_cfg_r  <= CNT_W'(16);
      scale_r     <= VAL_W'(256);
      nr_r        <= CNT_W'(1);
      nc_r        <= CNT_W'(1);
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ROWS:  rows_cfg_r <= cfg_data[CNT_W-1:0];
          CFG_COLS:  cols_cfg_r <= cfg_data[CNT_W-1:0];
          CFG_SCALE: scale_r    <= cfg_data;
          default:   ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_data.func == FUNC_VECTOR && in_data.last_element) begin
            nr_r    <= nr_nxt;
            nc_r    <= nc_nxt;
            row_r   <= '0;
            col_r   <= '0;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (col_end) begin
            state_r <= S_WAIT;
          end else begin
            col_r <= col_r + IDX_W'(1);
          end
        end
        S_WAIT: begin
          if (acc_done_r) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid_r             <= 1'b1;
          out_data_r.out_row      <= row_r;
          out_data_r.result_value <= sat_val;
          out_data_r.last_result  <= ({1'b0, row_r} == nr_r - CNT_W'(1));
          col_r                   <= '0;
          if ({1'b0, row_r} == nr_r - CNT_W'(1)) begin
            state_r <= S_IDLE;
          end else begin
            row_r   <= row_r + IDX_W'(1);
            state_r <= S_ISSUE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
